FILE: hw/rtl/q2e_pkg.sv
// shared types, constants and the arctangent table for the quaternion to euler block
// no dependencies
`default_nettype none
package q2e_pkg;
    localparam int unsigned CordicStagesDef = 16;
    localparam int unsigned AtanEntries = 24;
    localparam int unsigned TermW = 33;
    localparam int unsigned CordW = 36;
    localparam int unsigned SqrtInW = 58;
    localparam int unsigned SqrtOutW = 29;
    localparam logic signed [TermW-1:0] OneQ28 = 33'sd268435456;
    localparam logic [15:0] QuarterTurn = 16'd16384;
    localparam logic [15:0] NegQuarterTurn = 16'd49152;
    localparam logic [31:0] HalfTurn32 = 32'h8000_0000;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic pitch_clamped;
    } t_euler;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0: atan_entry = 32'h20000000;
            5'd1: atan_entry = 32'h12E4051E;
            5'd2: atan_entry = 32'h09FB385B;
            5'd3: atan_entry = 32'h051111D4;
            5'd4: atan_entry = 32'h028B0D43;
            5'd5: atan_entry = 32'h0145D7E1;
            5'd6: atan_entry = 32'h00A2F61E;
            5'd7: atan_entry = 32'h00517C55;
            5'd8: atan_entry = 32'h0028BE53;
            5'd9: atan_entry = 32'h00145F2F;
            5'd10: atan_entry = 32'h000A2F98;
            5'd11: atan_entry = 32'h000517CC;
            5'd12: atan_entry = 32'h00028BE6;
            5'd13: atan_entry = 32'h000145F3;
            5'd14: atan_entry = 32'h0000A2FA;
            5'd15: atan_entry = 32'h0000517D;
            5'd16: atan_entry = 32'h000028BE;
            5'd17: atan_entry = 32'h0000145F;
            5'd18: atan_entry = 32'h00000A30;
            5'd19: atan_entry = 32'h00000518;
            5'd20: atan_entry = 32'h0000028C;
            5'd21: atan_entry = 32'h00000146;
            5'd22: atan_entry = 32'h000000A3;
            5'd23: atan_entry = 32'h00000051;
            default: atan_entry = 32'h0;
        endcase
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/q2e_cordic.sv
// pipelined cordic vectoring unit, one stage per iteration, 16-bit binary angle out
// depends on q2e_pkg
`default_nettype none
module q2e_cordic
    import q2e_pkg::*;
#(
    parameter int unsigned STAGES = CordicStagesDef
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [CordW-1:0] i_y,
    input  wire logic signed [CordW-1:0] i_x,
    output logic [15:0]                  o_angle
);
    logic signed [CordW-1:0] r_x [STAGES+1];
    logic signed [CordW-1:0] r_y [STAGES+1];
    logic [31:0] r_ang [STAGES+1];
    logic r_zero [STAGES+1];
    logic [15:0] r_out;
    logic [31:0] n_rnd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_ang[0] <= HalfTurn32;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_ang[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_ang[g+1] <= r_ang[g] + atan_entry(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_ang[g+1] <= r_ang[g] - atan_entry(5'(g));
                end
            end
        end
    end

    assign n_rnd = r_ang[STAGES] + 32'h8000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_zero[STAGES] ? 16'h0 : n_rnd[31:16];
        end
    end

    assign o_angle = r_out;
endmodule
`default_nettype wire

FILE: hw/rtl/q2e_isqrt.sv
// pipelined restoring integer square root, one result bit per stage
// depends on q2e_pkg
`default_nettype none
module q2e_isqrt
    import q2e_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [SqrtInW-1:0] i_val,
    output logic [SqrtOutW-1:0]     o_root
);
    // partial remainder and root carried per stage, msb pair first
    logic [SqrtInW-1:0] r_val [SqrtOutW+1];
    logic [SqrtOutW+1:0] r_rem [SqrtOutW+1];
    logic [SqrtOutW-1:0] r_root [SqrtOutW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val[0] <= i_val;
            r_rem[0] <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar g = 0; g < SqrtOutW; g++) begin : g_bit
        logic [SqrtOutW+1:0] n_rem;
        logic [SqrtOutW+1:0] n_trial;
        assign n_rem = {r_rem[g][SqrtOutW-1:0], r_val[g][SqrtInW-1 -: 2]};
        assign n_trial = {r_root[g], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[g+1] <= {r_val[g][SqrtInW-3:0], 2'b00};
                if (n_rem >= n_trial) begin
                    r_rem[g+1] <= n_rem - n_trial;
                    r_root[g+1] <= {r_root[g][SqrtOutW-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= n_rem;
                    r_root[g+1] <= {r_root[g][SqrtOutW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SqrtOutW];
endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_to_euler_angles.sv
// quaternion to zyx euler angles, fully pipelined with cordic and square root units
// throughput: one request per cycle; the whole pipeline advances when the output is free
// reset clears the valid bits only; data registers carry no reset
// depends on q2e_pkg, q2e_cordic, q2e_isqrt
`default_nettype none
module quaternion_to_euler_angles
    import q2e_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_quat  i_data,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_euler      o_data
);
    localparam int unsigned Depth = 4 + SqrtOutW + CORDIC_STAGES + 2;
    localparam int unsigned DelayN = SqrtOutW + 1;

    logic en;
    logic [Depth-1:0] r_vld;
    logic r_oval;
    t_euler r_odat;

    assign en = !r_oval || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_oval <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
            r_oval <= r_vld[Depth-1];
        end
    end

    // stage 1: products
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_data.quat_w * i_data.quat_x;
            r_yz <= i_data.quat_y * i_data.quat_z;
            r_xx <= i_data.quat_x * i_data.quat_x;
            r_yy <= i_data.quat_y * i_data.quat_y;
            r_wz <= i_data.quat_w * i_data.quat_z;
            r_xy <= i_data.quat_x * i_data.quat_y;
            r_zz <= i_data.quat_z * i_data.quat_z;
            r_wy <= i_data.quat_w * i_data.quat_y;
            r_zx <= i_data.quat_z * i_data.quat_x;
        end
    end

    // stage 2: q28 terms, kept 2 bits wider for the cordic gain
    logic signed [CordW-1:0] r_sr, r_cr, r_sy, r_cy, r_sp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr <= (CordW'(r_wx) + CordW'(r_yz)) <<< 1;
            r_cr <= CordW'(OneQ28) - ((CordW'(r_xx) + CordW'(r_yy)) <<< 1);
            r_sy <= (CordW'(r_wz) + CordW'(r_xy)) <<< 1;
            r_cy <= CordW'(OneQ28) - ((CordW'(r_yy) + CordW'(r_zz)) <<< 1);
            r_sp <= (CordW'(r_wy) - CordW'(r_zx)) <<< 1;
        end
    end

    // stage 3: pitch clamp test and one minus the squared sine
    logic r_clamp;
    logic signed [CordW-1:0] r_sp3;
    logic [SqrtInW-1:0] r_rad;
    logic signed [29:0] sp_n;
    logic [59:0] sp_sq;
    assign sp_n = r_sp[29:0];
    assign sp_sq = 60'(sp_n * sp_n);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clamp <= (r_sp >= CordW'(OneQ28)) || (r_sp <= -CordW'(OneQ28));
            r_sp3 <= r_sp;
            r_rad <= SqrtInW'(60'h100_0000_0000_0000 - sp_sq);
        end
    end

    logic [SqrtOutW-1:0] cp;
    q2e_isqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_val(r_rad), .o_root(cp)
    );

    // delay line aligning the other terms with the square root
    logic signed [CordW-1:0] r_dsr [DelayN], r_dcr [DelayN], r_dsy [DelayN];
    logic signed [CordW-1:0] r_dcy [DelayN], r_dsp [DelayN];
    logic r_dcl [DelayN];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dsr[0] <= r_sr;
            r_dcr[0] <= r_cr;
            r_dsy[0] <= r_sy;
            r_dcy[0] <= r_cy;
            r_dsp[0] <= r_sp3;
            r_dcl[0] <= r_clamp;
            for (int k = 1; k < DelayN; k++) begin
                r_dsr[k] <= r_dsr[k-1];
                r_dcr[k] <= r_dcr[k-1];
                r_dsy[k] <= r_dsy[k-1];
                r_dcy[k] <= r_dcy[k-1];
                r_dsp[k] <= r_dsp[k-1];
                r_dcl[k] <= r_dcl[k-1];
            end
        end
    end
    // r_sr/r_cr/r_sy/r_cy are one stage ahead of r_sp3, compensate by one extra tap
    logic signed [CordW-1:0] r_asr, r_acr, r_asy, r_acy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_asr <= r_dsr[DelayN-1];
            r_acr <= r_dcr[DelayN-1];
            r_asy <= r_dsy[DelayN-1];
            r_acy <= r_dcy[DelayN-1];
        end
    end

    logic [15:0] roll_a, yaw_a, pitch_a;
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_y(r_asr), .i_x(r_acr), .o_angle(roll_a)
    );
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_y(r_asy), .i_x(r_acy), .o_angle(yaw_a)
    );
    q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_y(r_dsp[DelayN-1]), .i_x(CordW'(cp)),
        .o_angle(pitch_a)
    );

    // clamp flag and sign follow the cordic
    logic [CORDIC_STAGES+1:0] r_ccl;
    logic [CORDIC_STAGES+1:0] r_cpos;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ccl <= {r_ccl[CORDIC_STAGES:0], r_dcl[DelayN-1]};
            r_cpos <= {r_cpos[CORDIC_STAGES:0], r_dsp[DelayN-1] > 0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odat.roll_angle <= roll_a;
            r_odat.yaw_angle <= yaw_a;
            r_odat.pitch_clamped <= r_ccl[CORDIC_STAGES+1];
            if (r_ccl[CORDIC_STAGES+1]) begin
                r_odat.pitch_angle <= r_cpos[CORDIC_STAGES+1] ? QuarterTurn
                                                             : NegQuarterTurn;
            end else begin
                r_odat.pitch_angle <= pitch_a;
            end
        end
    end

    assign o_valid = r_oval;
    assign o_data = r_odat;
endmodule
`default_nettype wire

FILE: hw/rtl/q2e_checker.sv
// port-level checks for the quaternion to euler block, bound to the top level
// depends on q2e_pkg
`default_nettype none
module q2e_checker
    import q2e_pkg::*;
(
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   o_ready,
    input wire logic   o_valid,
    input wire logic   i_ready,
    input wire t_euler o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped or changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.pitch_clamped |->
        (o_data.pitch_angle == QuarterTurn || o_data.pitch_angle == NegQuarterTurn))
        else $error("clamped pitch not a quarter turn");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind quaternion_to_euler_angles q2e_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_data(o_data)
);
`default_nettype wire

FILE: tb/quaternion_to_euler_angles_tb.sv
// testbench for quaternion_to_euler_angles: random and directed quaternions checked
// against a fixed point euler angle predictor; depends on q2e_pkg and the block's rtl
`default_nettype none
module quaternion_to_euler_angles_tb
    import q2e_pkg::*;
();

    localparam int Stages = 16;
    localparam int Latency = 60;
    localparam longint CycleLimit = 2000000;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_quat  i_data;
    logic   o_valid;
    logic   i_ready;
    t_euler o_data;

    t_euler angles_due[$];
    int     mismatches;
    int     failed;
    longint cycles;
    int     send_idle_pct;
    int     stall_pct;
    int     hold_off;

    quaternion_to_euler_angles #(.CORDIC_STAGES(Stages)) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 60;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] atan_table(int i);
        logic [31:0] t [24];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return t[i];
    endfunction

    function automatic logic [15:0] binary_atan2(longint y, longint x);
        logic [31:0] ang;
        longint dx;
        longint dy;
        logic [31:0] step;
        ang = '0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = HalfTurn32;
        end
        for (int i = 0; i < Stages && i < AtanEntries; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            step = atan_table(i);
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                ang = ang + step;
            end else begin
                x = x - dx;
                y = y + dy;
                ang = ang - step;
            end
        end
        ang = ang + 32'h8000;
        return ang[31:16];
    endfunction

    function automatic t_euler euler_of(t_quat q);
        t_euler e;
        longint w, x, y, z, one, sp;
        w = q.quat_w;
        x = q.quat_x;
        y = q.quat_y;
        z = q.quat_z;
        one = 64'sd1 <<< 28;
        e.roll_angle = binary_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y));
        e.yaw_angle = binary_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z));
        sp = 2 * (w * y - z * x);
        if (sp >= one || sp <= -one) begin
            e.pitch_clamped = 1'b1;
            e.pitch_angle = (sp > 0) ? QuarterTurn : NegQuarterTurn;
        end else begin
            e.pitch_clamped = 1'b0;
            e.pitch_angle = binary_atan2(sp, root_floor((64'sd1 <<< 56) - sp * sp));
        end
        return e;
    endfunction

    // ready only changes at the rising edge, so its value at the falling edge holds there
    task automatic send_quat(t_quat q);
        logic took;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= q;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        angles_due.push_back(euler_of(q));
    endtask

    function automatic t_quat make_quat(int w, int x, int y, int z);
        t_quat q;
        q.quat_w = w[15:0];
        q.quat_x = x[15:0];
        q.quat_y = y[15:0];
        q.quat_z = z[15:0];
        return q;
    endfunction

    // unit quaternion-ish values with random content, plus raw noise
    function automatic t_quat random_quat();
        t_quat q;
        int sel;
        sel = $urandom_range(9, 0);
        q = t_quat'({$urandom, $urandom});
        if (sel < 6) begin
            q.quat_w = $signed(16'($urandom_range(16384, 0))) - 16'sd8192;
            q.quat_x = $signed(16'($urandom_range(16384, 0))) - 16'sd8192;
            q.quat_y = $signed(16'($urandom_range(16384, 0))) - 16'sd8192;
            q.quat_z = $signed(16'($urandom_range(16384, 0))) - 16'sd8192;
        end else if (sel < 8) begin
            q.quat_w = $signed(16'($urandom_range(23170, 0))) - 16'sd11585;
            q.quat_y = $signed(16'($urandom_range(23170, 0))) - 16'sd11585;
            q.quat_x = $signed(16'($urandom_range(64, 0))) - 16'sd32;
            q.quat_z = $signed(16'($urandom_range(64, 0))) - 16'sd32;
        end
        return q;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
    endtask

    task automatic test_directed();
        int v [6];
        v = '{-32768, 32767, 0, 16384, -16384, 1};
        send_quat(make_quat(16384, 0, 0, 0));
        send_quat(make_quat(0, 0, 0, 0));
        send_quat(make_quat(11585, 0, 11585, 0));
        send_quat(make_quat(11585, 0, -11585, 0));
        send_quat(make_quat(11585, 11585, 11585, 0));
        send_quat(make_quat(0, 16384, 0, 0));
        send_quat(make_quat(0, 0, 0, 16384));
        send_quat(make_quat(-16384, 0, 0, 1));
        send_quat(make_quat(-32768, -32768, -32768, -32768));
        send_quat(make_quat(32767, 32767, 32767, 32767));
        send_quat(make_quat(0, 11585, 0, 0));
        for (int i = 0; i < 6; i++)
            send_quat(make_quat(v[i], v[5 - i], v[(i + 2) % 6], v[(i + 4) % 6]));
        drain();
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) send_quat(random_quat());
        drain();
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 300;
        for (int i = 0; i < 120; i++) send_quat(random_quat());
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        mismatches = 0;
        failed = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(60, 0, 0);
        test_random(150, 81, 0);
        test_random(150, 0, 81);
        test_random(150, 35, 35);
        test_backpressure();
        test_random(150, 0, 0);
        if (failed == 0 && mismatches == 0) begin
            $display("quaternion_to_euler_angles_tb passed");
        end else begin
            $display("quaternion_to_euler_angles_tb failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            i_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_ready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_euler want;
        if (i_rst_n && o_valid && i_ready) begin
            if (angles_due.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_data);
            end else begin
                want = angles_due.pop_front();
                if (o_data.roll_angle !== want.roll_angle
                        || o_data.pitch_angle !== want.pitch_angle
                        || o_data.yaw_angle !== want.yaw_angle
                        || o_data.pitch_clamped !== want.pitch_clamped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want r %0d p %0d y %0d c %0d, %s",
                            want.roll_angle, want.pitch_angle, want.yaw_angle,
                            want.pitch_clamped,
                            $sformatf("got r %0d p %0d y %0d c %0d",
                                o_data.roll_angle, o_data.pitch_angle,
                                o_data.yaw_angle, o_data.pitch_clamped));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= (cycles === 'x) ? 0 : cycles + 1;
        if (cycles == CycleLimit) begin
            $display("quaternion_to_euler_angles_tb failed");
            $finish;
        end
    end
endmodule
`default_nettype wire
